// ===== rtl/core/annexb_nal_unit_splitter_unit_macros.svh =====
// Assertion macros used by the splitter checker.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_UNIT_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_UNIT_MACROS_SVH

// Check an implication in the same cycle, disabled during reset.
`define ANNEXB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("splitter check failed");

// Check an implication in the following cycle, disabled during reset.
`define ANNEXB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("splitter check failed");

`endif

// ===== rtl/core/annexb_pkg.sv =====
// Shared types and constants of the Annex-B NAL unit splitter.
package annexb_pkg;

    localparam int POS_BITS  = 24;
    localparam int BYTE_W    = 8;
    localparam int OFFSET_W  = 24;
    localparam int LENGTH_W  = 25;
    localparam int HEADER_W  = 8;
    localparam int TYPE_W    = 5;
    localparam int FIELDS_W  = OFFSET_W + LENGTH_W + HEADER_W + TYPE_W;
    localparam int M_TDATA_W = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W     = M_TDATA_W - FIELDS_W;
    localparam int S_TDATA_W = 8;

    localparam logic [HEADER_W-1:0] TYPE_MASK = 8'h1f;
    localparam logic [1:0]          ZRUN_MAX  = 2'd2;
    localparam logic [BYTE_W-1:0]   SC_BYTE   = 8'h01;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } beat_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic [HEADER_W-1:0] header;
        logic                at_end;
        logic                too_long;
    } desc_t;

endpackage

// ===== rtl/core/annexb_in_stage.sv =====
// Input register stage of the splitter.
module annexb_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  annexb_pkg::beat_t    s_beat,
    output logic                 valid,
    output annexb_pkg::beat_t    beat,
    input  logic                 take
);
    import annexb_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;
    assign valid      = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            beat_reg <= s_beat;
        end
    end

endmodule

// ===== rtl/core/annexb_parse.sv =====
// Start code scanner and unit tracking state of the splitter.
module annexb_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    input  annexb_pkg::beat_t    beat,
    input  logic                 ready,
    output logic                 desc_valid,
    output annexb_pkg::desc_t    desc
);
    import annexb_pkg::*;

    logic [1:0]          zero_run_reg,  zero_run_next;
    logic [POS_BITS-1:0] position_reg,  position_next;
    logic                unit_open_reg, unit_open_next;
    logic [POS_BITS-1:0] unit_begin_reg, unit_begin_next;
    logic [POS_BITS:0]   content_end_reg, content_end_next;
    logic                hdr_pending_reg, hdr_pending_next;
    logic [HEADER_W-1:0] hdr_value_reg,  hdr_value_next;
    logic                saturated_reg,  saturated_next;

    logic                fire;
    logic                at_max;
    logic                is_zero;
    logic                sc;
    logic [POS_BITS:0]   pos_inc;
    logic [POS_BITS:0]   begin_ext;
    logic [POS_BITS:0]   end_sel;
    logic [HEADER_W-1:0] hdr_sel;
    logic                sat_sel;
    logic                emit;

    assign fire    = valid && ready;
    assign at_max  = &position_reg;
    assign is_zero = (beat.data == '0);
    assign sc      = (beat.data == SC_BYTE) && (zero_run_reg >= ZRUN_MAX);
    assign pos_inc = (POS_BITS+1)'(position_reg) + (POS_BITS+1)'(1);
    assign begin_ext = (POS_BITS+1)'(unit_begin_reg);

    always_comb
    begin
        zero_run_next    = zero_run_reg;
        unit_open_next   = unit_open_reg;
        unit_begin_next  = unit_begin_reg;
        content_end_next = content_end_reg;
        hdr_pending_next = hdr_pending_reg;
        hdr_value_next   = hdr_value_reg;
        position_next    = at_max ? position_reg : pos_inc[POS_BITS-1:0];
        saturated_next   = saturated_reg || at_max;

        if (sc)
        begin
            unit_open_next   = 1'b1;
            unit_begin_next  = at_max ? position_reg : pos_inc[POS_BITS-1:0];
            content_end_next = (POS_BITS+1)'(unit_begin_next);
            hdr_pending_next = 1'b1;
            zero_run_next    = '0;
        end
        else
        begin
            if (unit_open_reg)
            begin
                if (hdr_pending_reg)
                begin
                    hdr_value_next   = beat.data;
                    hdr_pending_next = 1'b0;
                end
                if (!is_zero)
                begin
                    content_end_next = pos_inc;
                end
            end
            if (is_zero)
            begin
                zero_run_next = (zero_run_reg < ZRUN_MAX) ? zero_run_reg + 2'd1 : ZRUN_MAX;
            end
            else
            begin
                zero_run_next = '0;
            end
        end
    end

    // close on a start code uses the state before this byte
    always_comb
    begin
        if (sc)
        begin
            end_sel = content_end_reg;
            hdr_sel = hdr_value_reg;
            sat_sel = saturated_reg;
            emit    = unit_open_reg;
        end
        else
        begin
            end_sel = content_end_next;
            hdr_sel = hdr_value_next;
            sat_sel = saturated_next;
            emit    = unit_open_reg && beat.last;
        end
    end

    assign desc_valid    = fire && emit && (end_sel > begin_ext);
    assign desc.offset   = OFFSET_W'(unit_begin_reg);
    assign desc.length   = LENGTH_W'(end_sel - begin_ext);
    assign desc.header   = hdr_sel;
    assign desc.at_end   = beat.last;
    assign desc.too_long = sat_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg    <= '0;
            position_reg    <= '0;
            unit_open_reg   <= 1'b0;
            unit_begin_reg  <= '0;
            content_end_reg <= '0;
            hdr_pending_reg <= 1'b0;
            hdr_value_reg   <= '0;
            saturated_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (beat.last)
            begin
                zero_run_reg    <= '0;
                position_reg    <= '0;
                unit_open_reg   <= 1'b0;
                unit_begin_reg  <= '0;
                content_end_reg <= '0;
                hdr_pending_reg <= 1'b0;
                hdr_value_reg   <= '0;
                saturated_reg   <= 1'b0;
            end
            else
            begin
                zero_run_reg    <= zero_run_next;
                position_reg    <= position_next;
                unit_open_reg   <= unit_open_next;
                unit_begin_reg  <= unit_begin_next;
                content_end_reg <= content_end_next;
                hdr_pending_reg <= hdr_pending_next;
                hdr_value_reg   <= hdr_value_next;
                saturated_reg   <= saturated_next;
            end
        end
    end

endmodule

// ===== rtl/core/annexb_out_stage.sv =====
// Descriptor output register of the splitter.
module annexb_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              desc_valid,
    input  annexb_pkg::desc_t                 desc,
    output logic                              ready,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [annexb_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);
    import annexb_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    desc_t desc_reg;
    logic [HEADER_W-1:0] type_full;

    assign ready      = !valid_reg || m_tready;
    assign valid_next = ready ? desc_valid : valid_reg;
    assign type_full  = desc_reg.header & TYPE_MASK;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {PAD_W'(0), type_full[TYPE_W-1:0], desc_reg.header,
                       desc_reg.length, desc_reg.offset};
    assign m_tlast  = desc_reg.at_end;
    assign m_tuser  = desc_reg.too_long;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && desc_valid)
        begin
            desc_reg <= desc;
        end
    end

endmodule

// ===== rtl/core/annexb_nal_unit_splitter_unit.sv =====
// Top level of the Annex-B NAL unit splitter.
// A descriptor is registered in the output stage after its closing beat passes the input register and scanner.
// Throughput: 1 byte beat per cycle while m_tready backpressure does not stall the output.
// Stalls on m_tready backpressure reach s_tready combinationally once both registers hold data.
// Reset (rst_n low, async) clears the scanner state and empties both registers.
// A beat with s_tlast also clears the scanner state after it is processed.
module annexb_nal_unit_splitter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [annexb_pkg::S_TDATA_W-1:0]  s_tdata,   // data_byte
    input  logic                              s_tlast,   // last_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [annexb_pkg::M_TDATA_W-1:0]  m_tdata,   // nal_offset, nal_length, nal_header, nal_type, pad
    output logic                              m_tlast,   // at_buffer_end
    output logic                              m_tuser    // too_long
);
    import annexb_pkg::*;

    beat_t s_beat;
    beat_t in_beat;
    logic  in_valid;
    logic  out_ready;
    logic  desc_valid;
    desc_t desc;

    assign s_beat.data = s_tdata[BYTE_W-1:0];
    assign s_beat.last = s_tlast;

    annexb_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_beat   (s_beat),
        .valid    (in_valid),
        .beat     (in_beat),
        .take     (out_ready)
    );

    annexb_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (in_valid),
        .beat       (in_beat),
        .ready      (out_ready),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    annexb_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .ready      (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== rtl/core/annexb_checker.sv =====
// Port-level checker of the splitter, bound to the top level.
`include "annexb_nal_unit_splitter_unit_macros.svh"

module annexb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    `ANNEXB_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    `ANNEXB_ASSERT_NOW(a_type_matches_header, clk, rst_n, m_tvalid, m_tdata[61:57] == m_tdata[53:49])

    `ANNEXB_ASSERT_NOW(a_length_nonzero, clk, rst_n, m_tvalid, m_tdata[48:24] != 25'd0)

    `ANNEXB_ASSERT_NOW(a_stall_only_on_backpressure, clk, rst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind annexb_nal_unit_splitter_unit annexb_checker u_annexb_checker (.*);
